// ----- sv/bpd_pkg.sv -----
// Package for the baseband packet deframer: parse phases, byte kinds,
// status codes and the per-byte result record. No dependencies.
package bpd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned PTR_W  = 13;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned STAT_W = 3;

  localparam logic [PTR_W-1:0] PAD_POINTER = 13'h1FFF;

  typedef enum logic [2:0] {
    PH_BASE1   = 3'd0,
    PH_BASE2   = 3'd1,
    PH_OPT1    = 3'd2,
    PH_OPT2    = 3'd3,
    PH_EXT     = 3'd4,
    PH_PRE     = 3'd5,
    PH_POST    = 3'd6,
    PH_DISCARD = 3'd7
  } phase_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_BASE    = 3'd0,
    KIND_OPTION  = 3'd1,
    KIND_EXT     = 3'd2,
    KIND_PRE     = 3'd3,
    KIND_POST    = 3'd4,
    KIND_DISCARD = 3'd5
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK          = 3'd0,
    ST_PADDING     = 3'd1,
    ST_SHORT_HDR   = 3'd2,
    ST_PTR_AT_END  = 3'd3,
    ST_PTR_PAST    = 3'd4
  } status_t;

  localparam logic [MODE_W-1:0] MODE_NONE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SHORT = 2'd1;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    kind_t             byte_kind;
    logic              region_first;
    logic              out_last;
    logic [PTR_W-1:0]  packet_pointer;
    logic [2:0]        extension_type;
    logic [PTR_W-1:0]  extension_length;
    logic [MODE_W-1:0] option_mode;
    status_t           status;
  } result_t;

endpackage

// ----- sv/bpd_if.sv -----
// Handshake channels of the deframer: packet bytes in, labeled bytes out.
// Depends on bpd_pkg.
interface bpd_byte_if;
  import bpd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              in_last;
  modport source (output valid, in_byte, in_last, input ready);
  modport sink   (input valid, in_byte, in_last, output ready);
endinterface

interface bpd_result_if;
  import bpd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic [KIND_W-1:0] byte_kind;
  logic              region_first;
  logic              out_last;
  logic [PTR_W-1:0]  packet_pointer;
  logic [2:0]        extension_type;
  logic [PTR_W-1:0]  extension_length;
  logic [MODE_W-1:0] option_mode;
  logic [STAT_W-1:0] status;
  modport source (output valid, out_byte, byte_kind, region_first, out_last,
                  packet_pointer, extension_type, extension_length,
                  option_mode, status, input ready);
  modport sink   (input valid, out_byte, byte_kind, region_first, out_last,
                  packet_pointer, extension_type, extension_length,
                  option_mode, status, output ready);
endinterface

// ----- sv/bpd_parser.sv -----
// Header parser state and per-byte labeling logic.
// Depends on bpd_pkg.
module bpd_parser (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic [bpd_pkg::BYTE_W-1:0] item_byte,
  input  logic                   item_last,
  output bpd_pkg::result_t       result,
  output bpd_pkg::phase_t        phase
);
  import bpd_pkg::*;

  logic [PTR_W-1:0]  pointer_value, pointer_value_next;
  logic [MODE_W-1:0] ext_mode, ext_mode_next;
  logic [2:0]        ext_kind, ext_kind_next;
  logic [PTR_W-1:0]  ext_bytes, ext_bytes_next;
  logic [PTR_W-1:0]  countdown, countdown_next;
  logic              post_seen, post_seen_next;
  phase_t            phase_next;

  kind_t             kind;
  logic              first;
  logic              pad;
  logic [PTR_W-1:0]  pre_left;
  logic [PTR_W-1:0]  cd_dec;
  status_t           st;

  always_ff @(posedge clk) begin
    if (rst || (step && item_last)) begin
      phase         <= PH_BASE1;
      pointer_value <= '0;
      ext_mode      <= '0;
      ext_kind      <= '0;
      ext_bytes     <= '0;
      countdown     <= '0;
      post_seen     <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      pointer_value <= pointer_value_next;
      ext_mode      <= ext_mode_next;
      ext_kind      <= ext_kind_next;
      ext_bytes     <= ext_bytes_next;
      countdown     <= countdown_next;
      post_seen     <= post_seen_next;
    end
  end

  assign cd_dec = countdown - PTR_W'(1);

  always_comb begin
    phase_next         = phase;
    pointer_value_next = pointer_value;
    ext_mode_next      = ext_mode;
    ext_kind_next      = ext_kind;
    ext_bytes_next     = ext_bytes;
    countdown_next     = countdown;
    post_seen_next     = post_seen;
    kind               = KIND_DISCARD;
    first              = 1'b0;
    pad                = 1'b0;
    pre_left           = '0;

    // header_done: zero pointer goes straight to post-pointer data
    case (phase)
      PH_BASE1: begin
        kind               = KIND_BASE;
        pointer_value_next = {6'b0, item_byte[6:0]};
        ext_mode_next      = '0;
        ext_kind_next      = '0;
        ext_bytes_next     = '0;
        countdown_next     = '0;
        post_seen_next     = 1'b0;
        if (item_byte[7]) begin
          phase_next = PH_BASE2;
        end else if (item_byte[6:0] == 7'd0) begin
          phase_next = PH_POST;
        end else begin
          phase_next     = PH_PRE;
          countdown_next = {6'b0, item_byte[6:0]};
        end
      end
      PH_BASE2: begin
        kind               = KIND_BASE;
        pointer_value_next = pointer_value | {item_byte[7:2], 7'b0};
        if (pointer_value_next == PAD_POINTER) begin
          phase_next = PH_DISCARD;
          pad        = 1'b1;
        end else begin
          ext_mode_next = item_byte[1:0];
          if (item_byte[1:0] != MODE_NONE) begin
            phase_next = PH_OPT1;
          end else if (pointer_value_next == '0) begin
            phase_next = PH_POST;
          end else begin
            phase_next     = PH_PRE;
            countdown_next = pointer_value_next;
          end
        end
      end
      PH_OPT1, PH_OPT2: begin
        kind = KIND_OPTION;
        if (phase == PH_OPT1) begin
          ext_kind_next  = item_byte[7:5];
          ext_bytes_next = {8'b0, item_byte[4:0]};
        end else begin
          ext_bytes_next = ext_bytes | {item_byte, 5'b0};
        end
        if (phase == PH_OPT1 && ext_mode != MODE_SHORT) begin
          phase_next = PH_OPT2;
        end else if (ext_bytes_next != '0) begin
          phase_next     = PH_EXT;
          countdown_next = ext_bytes_next;
        end else if (pointer_value == '0) begin
          phase_next = PH_POST;
        end else begin
          phase_next     = PH_PRE;
          countdown_next = pointer_value;
        end
      end
      PH_EXT: begin
        kind           = KIND_EXT;
        countdown_next = cd_dec;
        if (cd_dec == '0) begin
          if (pointer_value == '0) begin
            phase_next = PH_POST;
          end else begin
            phase_next     = PH_PRE;
            countdown_next = pointer_value;
          end
        end
      end
      PH_PRE: begin
        kind           = KIND_PRE;
        first          = (countdown == pointer_value);
        pre_left       = countdown;
        countdown_next = cd_dec;
        if (cd_dec == '0) begin
          phase_next = PH_POST;
        end
      end
      PH_POST: begin
        kind           = KIND_POST;
        first          = !post_seen;
        post_seen_next = 1'b1;
      end
      default: begin
        kind = KIND_DISCARD;
      end
    endcase
  end

  always_comb begin
    st = ST_OK;
    if (item_last) begin
      case (kind)
        KIND_BASE, KIND_OPTION, KIND_EXT: st = pad ? ST_PADDING : ST_SHORT_HDR;
        KIND_PRE:     st = (pre_left == PTR_W'(1)) ? ST_PTR_AT_END : ST_PTR_PAST;
        KIND_DISCARD: st = ST_PADDING;
        default:      st = ST_OK;
      endcase
    end
  end

  always_comb begin
    result.out_byte         = item_byte;
    result.byte_kind        = kind;
    result.region_first     = first;
    result.out_last         = item_last;
    result.packet_pointer   = pointer_value_next;
    result.extension_type   = ext_kind_next;
    result.extension_length = ext_bytes_next;
    result.option_mode      = ext_mode_next;
    result.status           = st;
  end

endmodule

// ----- sv/bpd_out_stage.sv -----
// Result register that drives the output channel.
// Depends on bpd_pkg and bpd_result_if.
module bpd_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  bpd_pkg::result_t result,
  output logic             free,
  bpd_result_if.source     res
);
  import bpd_pkg::*;

  logic    valid;
  result_t data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (res.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= result;
    end
  end

  assign free                 = !valid || res.ready;
  assign res.valid            = valid;
  assign res.out_byte         = data.out_byte;
  assign res.byte_kind        = data.byte_kind;
  assign res.region_first     = data.region_first;
  assign res.out_last         = data.out_last;
  assign res.packet_pointer   = data.packet_pointer;
  assign res.extension_type   = data.extension_type;
  assign res.extension_length = data.extension_length;
  assign res.option_mode      = data.option_mode;
  assign res.status           = data.status;

endmodule

// ----- sv/baseband_packet_deframer_top.sv -----
// Baseband packet deframer: labels each byte of a baseband packet.
// Path: input reg, parser, result reg; the header state update is a single pass.
// Throughput: one byte per cycle while the result channel is ready.
// Reset: rst (sync, active high) empties both registers and returns the
//   parser to the first base field byte; it also resets after every last byte.
// Depends on bpd_pkg, bpd_if, bpd_parser, bpd_out_stage.
module baseband_packet_deframer_top (
  input  logic       clk,
  input  logic       rst,
  bpd_byte_if.sink   packet,
  bpd_result_if.source result
);
  import bpd_pkg::*;

  // Input register: holds one byte transaction ahead of the parser.
  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              s1_last;

  logic    out_free;
  logic    advance;
  result_t parsed;
  phase_t  phase;

  // A byte moves into the result register when that register is free; the
  // parser state commits on the same edge.
  assign advance      = s1_valid && out_free;
  assign packet.ready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (packet.ready) begin
      s1_valid <= packet.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (packet.valid && packet.ready) begin
      s1_byte <= packet.in_byte;
      s1_last <= packet.in_last;
    end
  end

  bpd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .item_byte (s1_byte),
    .item_last (s1_last),
    .result    (parsed),
    .phase     (phase)
  );

  bpd_out_stage u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (advance),
    .result (parsed),
    .free   (out_free),
    .res    (result)
  );

  // Status is only reported on the last byte of a packet.
  a_status_on_last: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.out_last) |-> (result.status == ST_OK))
    else $error("nonzero status on a byte that is not last");

  // Region start marks only appear on payload bytes.
  a_first_on_payload: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.region_first) |->
      (result.byte_kind == KIND_PRE || result.byte_kind == KIND_POST))
    else $error("region start on a header or discarded byte");

  // Parser restarts at the base field after a packet's last byte.
  a_restart: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_last) |=> (phase == PH_BASE1))
    else $error("parser did not restart after last byte");

endmodule
